### rtl/epsilon_greedy_bandit_agent_defines.svh
// assertion macros for the bandit agent
`ifndef EPSILON_GREEDY_BANDIT_AGENT_DEFINES_SVH
`define EPSILON_GREEDY_BANDIT_AGENT_DEFINES_SVH
`ifndef SYNTHESIS
`define EGB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EGB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EGB_ASSERT(label, clk, rst, prop, msg)
`define EGB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/egb_pkg.sv
package egb_pkg;

  localparam int MAX_ARMS = 16;

  typedef struct packed {
    logic               action;
    logic [3:0]         arm;
    logic signed [31:0] reward;
    logic [15:0]        rand_explore;
    logic [15:0]        rand_arm;
    logic [15:0]        rand_tie;
  } egb_in_t;

  typedef struct packed {
    logic [3:0]         selected_arm;
    logic               explored;
    logic signed [31:0] estimate;
    logic [4:0]         tie_count;
  } egb_out_t;

  localparam logic ACT_CHOOSE = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam logic CFG_EPSILON   = 1'b0;
  localparam logic CFG_ARM_COUNT = 1'b1;

  localparam logic [16:0] EPSILON_RESET   = 17'd6554;
  localparam logic [4:0]  ARM_COUNT_RESET = 5'd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TIE_MOD,
    ST_TIE_FIND,
    ST_ARM_MOD,
    ST_PICK_RD,
    ST_UPD_RD,
    ST_UPD_DIV,
    ST_UPD_WR,
    ST_OUT,
    ST_CLEAR
  } egb_state_t;

endpackage

### rtl/egb_ram.sv
module egb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/epsilon_greedy_bandit_agent.sv
// Epsilon-greedy bandit agent. Estimates (Q16.16) and pull counts live in two
// single-port-read RAMs, cleared by a pass over all MAX_ARMS words after reset
// during which no word is accepted. A choose word scans the arms in use one per
// cycle, reduces rand_tie and rand_arm modulo small counts with a restoring
// divider, walks the arms again to find the chosen tie, and reads the pick. An
// update word reads the arm, runs a 33-step restoring signed division by the
// pull count and writes back. One word is in flight at a time; the result sits
// in an output register and the next word is taken once it leaves.
`include "epsilon_greedy_bandit_agent_defines.svh"
module epsilon_greedy_bandit_agent
  import egb_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  egb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output egb_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int AW = $clog2(MAX_ARMS);
  localparam int NW = $clog2(MAX_ARMS + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  egb_state_t state, state_next;

  logic [16:0] epsilon_level;
  logic [4:0]  arm_count;
  egb_in_t     item;
  egb_out_t    result;
  logic        result_valid;

  // scan state
  logic [NW-1:0] idx;
  logic [NW-1:0] n_eff;
  logic          have_best;
  logic signed [31:0] best;
  logic [NW-1:0] nties;
  logic [NW-1:0] tie_sel;
  logic [AW-1:0] pick;
  logic          explore;

  // divider: 33-bit dividend magnitude, up to 32-bit divisor
  logic [32:0] quo;
  logic [32:0] rem;
  logic [32:0] dvs;
  logic [5:0]  dcnt;
  logic        neg;

  // memories
  logic               est_we, cnt_we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        est_wdata, est_rdata;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [AW-1:0]      clr_idx;
  logic signed [31:0] upd_est;

  egb_ram #(.WIDTH(32), .DEPTH(MAX_ARMS)) u_est (
    .clk(clk), .we(est_we), .waddr(waddr), .wdata(est_wdata),
    .raddr(raddr), .rdata(est_rdata)
  );
  egb_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_ARMS)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(waddr), .wdata(cnt_wdata),
    .raddr(raddr), .rdata(cnt_rdata)
  );

  assign in_ready  = (state == ST_IDLE) && !result_valid;
  assign cfg_ready = 1'b1;
  assign out_valid = result_valid;
  assign out_data  = result;

  logic arm_ok;
  assign arm_ok = ({1'b0, item.arm} < 5'(MAX_ARMS));

  logic [COUNT_BITS-1:0] cnt_inc;
  assign cnt_inc = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;

  // difference against the estimate read for the update
  logic signed [32:0] diff;
  assign diff = 33'($signed(item.reward)) - 33'($signed(est_rdata));

  logic [33:0] trial;
  assign trial = {rem, quo[32]} - {1'b0, dvs};

  logic signed [32:0] step_q;
  assign step_q = neg ? -$signed(quo) : $signed(quo);

  // tie count including the word read in the last scan cycle
  function automatic logic [NW-1:0] nties_final(
    input logic hb, input logic signed [31:0] b, input logic [31:0] rd,
    input logic [NW-1:0] nt, input logic [NW-1:0] ix);
    logic [NW-1:0] r;
    r = nt;
    if (ix != '0) begin
      if (!hb || $signed(rd) > b) r = NW'(1);
      else if ($signed(rd) == b) r = nt + 1'b1;
    end
    return r;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_idx == AW'(MAX_ARMS - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid && in_ready) begin
        state_next = (in_data.action == ACT_UPDATE) ? ST_UPD_RD : ST_SCAN;
      end
      ST_SCAN:     if (idx == n_eff) state_next = ST_TIE_MOD;
      ST_TIE_MOD:  if (dcnt == 6'd0) state_next = ST_TIE_FIND;
      ST_TIE_FIND: if (idx == n_eff) state_next = ST_ARM_MOD;
      ST_ARM_MOD:  if (dcnt == 6'd0) state_next = ST_PICK_RD;
      ST_PICK_RD:  state_next = ST_OUT;
      ST_UPD_RD:   state_next = arm_ok ? ST_UPD_DIV : ST_OUT;
      ST_UPD_DIV:  if (dcnt == 6'd0) state_next = ST_UPD_WR;
      ST_UPD_WR:   state_next = ST_OUT;
      ST_OUT:      state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    est_we    = 1'b0;
    cnt_we    = 1'b0;
    waddr     = item.arm[AW-1:0];
    est_wdata = 32'(upd_est + step_q[31:0]);
    cnt_wdata = dvs[COUNT_BITS-1:0];
    raddr     = idx[AW-1:0];
    unique case (state)
      ST_CLEAR: begin
        est_we = 1'b1; cnt_we = 1'b1; waddr = clr_idx;
        est_wdata = '0; cnt_wdata = '0;
      end
      ST_IDLE:    raddr = in_data.arm[AW-1:0];
      ST_UPD_RD:  raddr = item.arm[AW-1:0];
      ST_ARM_MOD: raddr = explore ? rem[AW-1:0] : pick;
      ST_UPD_WR: begin
        est_we = 1'b1; cnt_we = 1'b1;
      end
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      epsilon_level <= EPSILON_RESET;
      arm_count     <= ARM_COUNT_RESET;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_EPSILON) epsilon_level <= cfg_data;
        else arm_count <= cfg_data[4:0];
      end
      if (out_valid && out_ready) result_valid <= 1'b0;
      if (state == ST_OUT) result_valid <= 1'b1;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state) inside
      ST_IDLE: begin
        item      <= in_data;
        idx       <= '0;
        have_best <= 1'b0;
        nties     <= '0;
        if (arm_count == 5'd0) n_eff <= NW'(1);
        else if (32'(arm_count) > 32'(MAX_ARMS)) n_eff <= NW'(MAX_ARMS);
        else n_eff <= NW'(arm_count);
        explore <= ({1'b0, in_data.rand_explore} <= epsilon_level);
      end
      ST_SCAN: begin
        // read data for arm idx-1 arrives this cycle
        if (idx != '0) begin
          if (!have_best || $signed(est_rdata) > best) begin
            best <= $signed(est_rdata); nties <= NW'(1); have_best <= 1'b1;
          end else if ($signed(est_rdata) == best) begin
            nties <= nties + 1'b1;
          end
        end
        if (idx == n_eff) begin
          quo <= {item.rand_tie, 17'd0}; rem <= '0;
          dvs <= 33'(nties_final(have_best, best, est_rdata, nties, idx));
          dcnt <= 6'd16;
        end
        idx <= idx + 1'b1;
      end
      ST_TIE_MOD, ST_ARM_MOD: begin
        if (dcnt != 6'd0) begin
          if (!trial[33]) rem <= trial[32:0];
          else rem <= {rem[31:0], quo[32]};
          quo  <= {quo[31:0], 1'b0};
          dcnt <= dcnt - 1'b1;
        end else if (state == ST_TIE_MOD) begin
          tie_sel <= rem[NW-1:0]; idx <= '0;
        end
      end
      ST_TIE_FIND: begin
        if (idx != '0 && $signed(est_rdata) == best) begin
          if (tie_sel == '0) pick <= AW'(idx - 1'b1);
          tie_sel <= tie_sel - 1'b1;
        end
        if (idx == n_eff) begin
          quo <= {item.rand_arm, 17'd0}; rem <= '0;
          dvs <= 33'(n_eff); dcnt <= 6'd16;
        end
        idx <= idx + 1'b1;
      end
      ST_PICK_RD: begin
        result.selected_arm <= explore ? 4'(rem[AW-1:0]) : 4'(pick);
        result.explored     <= explore;
        result.estimate     <= $signed(est_rdata);
        result.tie_count    <= 5'(nties);
      end
      ST_UPD_RD: begin
        // load the divider with |reward - estimate| and the new count
        upd_est <= $signed(est_rdata);
        neg     <= diff[32];
        quo     <= diff[32] ? 33'(-diff) : 33'(diff);
        rem     <= '0;
        dvs     <= 33'(cnt_inc);
        dcnt    <= 6'd33;
        result.selected_arm <= item.arm;
        result.explored     <= 1'b0;
        result.estimate     <= '0;
        result.tie_count    <= '0;
      end
      ST_UPD_DIV: begin
        if (dcnt != 6'd0) begin
          if (!trial[33]) rem <= trial[32:0];
          else rem <= {rem[31:0], quo[32]};
          quo  <= {quo[31:0], !trial[33]};
          dcnt <= dcnt - 1'b1;
        end
      end
      ST_UPD_WR:  result.estimate <= $signed(32'(upd_est + step_q[31:0]));
      default: ;
    endcase
  end

  `EGB_ASSERT(a_ready_idle, clk, rst, in_ready |-> state == ST_IDLE, "ready outside idle")
  `EGB_ASSERT(a_out_after, clk, rst, $rose(out_valid) |-> $past(state) == ST_OUT, "stray result")
  `EGB_ASSERT(a_no_take, clk, rst, out_valid |-> !in_ready, "accept with result pending")
  `EGB_ASSERT(a_ties, clk, rst, (state == ST_PICK_RD) |-> nties != '0, "no ties")

endmodule

### bench/tb_epsilon_greedy_bandit_agent.sv
`timescale 1ns / 1ps
module tb_epsilon_greedy_bandit_agent;
  import egb_pkg::*;

  localparam int ARMS = 16;
  localparam logic [23:0] PULL_MAX = 24'hFFFFFF;
  localparam int CYCLE_LIMIT = 900000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  egb_in_t in_data;
  logic out_valid;
  logic out_ready;
  egb_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [16:0] cfg_data;

  epsilon_greedy_bandit_agent i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted agent state
  logic signed [31:0] est_mem [ARMS];
  logic [23:0] pulls [ARMS];
  logic [16:0] eps_q;
  logic [4:0] arms_q;

  egb_in_t word_q[$];
  egb_out_t pick_q[$];
  int errors;
  int cycles;
  int in_idle;
  int out_idle;
  bit calm;

  // expected result of one input word, advancing predicted state
  function automatic egb_out_t bandit_predict(egb_in_t w);
    egb_out_t r;
    int n;
    int nt;
    int ties [ARMS];
    int pick;
    longint best;
    longint v;
    longint diff;
    r = '0;
    if (w.action == ACT_UPDATE) begin
      if (pulls[w.arm] != PULL_MAX) pulls[w.arm] = pulls[w.arm] + 24'd1;
      diff = longint'($signed(w.reward)) - longint'(est_mem[w.arm]);
      est_mem[w.arm] = 32'(longint'(est_mem[w.arm]) + diff / longint'(pulls[w.arm]));
      r.selected_arm = w.arm;
      r.estimate = est_mem[w.arm];
    end else begin
      n = arms_q;
      if (n < 1) n = 1;
      if (n > ARMS) n = ARMS;
      nt = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        v = est_mem[i];
        if (nt == 0 || v > best) begin
          best = v;
          nt = 0;
        end
        if (v == best) begin
          ties[nt] = i;
          nt++;
        end
      end
      pick = ties[int'(w.rand_tie) % nt];
      if (17'(w.rand_explore) <= eps_q) begin
        pick = int'(w.rand_arm) % n;
        r.explored = 1'b1;
      end
      r.selected_arm = 4'(pick);
      r.estimate = est_mem[pick];
      r.tie_count = 5'(nt);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic egb_in_t make_word(bit act, logic [3:0] a, logic [31:0] rw,
                                        logic [15:0] re, logic [15:0] ra, logic [15:0] rt);
    egb_in_t w;
    w.action = act;
    w.arm = a;
    w.reward = rw;
    w.rand_explore = re;
    w.rand_arm = ra;
    w.rand_tie = rt;
    return w;
  endfunction

  function automatic egb_in_t random_word();
    logic [31:0] rw;
    case ($urandom_range(0, 3))
      0: rw = $urandom;
      1: rw = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: rw = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: rw = 32'($urandom_range(0, 3) << 16);
    endcase
    return make_word(1'($urandom_range(0, 1)), 4'($urandom), rw,
                     16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_idle <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) begin
        pick_q.push_back(bandit_predict(in_data));
      end
      if (in_idle > 0) begin
        in_idle <= in_idle - 1;
        in_valid <= 1'b0;
      end else if (word_q.size() > 0 && !(in_valid && in_ready && word_q.size() == 0)) begin
        in_data <= word_q.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) in_idle <= $urandom_range(1, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor and ready control
  always @(posedge clk) begin
    egb_out_t e;
    if (rst) begin
      out_ready <= 1'b0;
      out_idle <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pick_q.size() == 0) begin
          report_mismatch("unexpected word", out_data.selected_arm, -1);
        end else begin
          e = pick_q.pop_front();
          if (out_data.selected_arm !== e.selected_arm)
            report_mismatch("selected_arm", out_data.selected_arm, e.selected_arm);
          if (out_data.explored !== e.explored)
            report_mismatch("explored", out_data.explored, e.explored);
          if (out_data.estimate !== e.estimate)
            report_mismatch("estimate", out_data.estimate, e.estimate);
          if (out_data.tie_count !== e.tie_count)
            report_mismatch("tie_count", out_data.tie_count, e.tie_count);
        end
      end
      if (out_idle > 0) begin
        out_idle <= out_idle - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_idle <= $urandom_range(1, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_epsilon_greedy_bandit_agent: errors");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [16:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_EPSILON) eps_q = val;
    else arms_q = val[4:0];
  endtask

  task automatic drain();
    while (word_q.size() > 0 || in_valid || pick_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    logic [16:0] eps_set [6];
    logic [4:0] arm_set [6];
    errors = 0;
    cycles = 0;
    calm = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = CFG_EPSILON;
    cfg_data = '0;
    for (int i = 0; i < ARMS; i++) begin
      est_mem[i] = 0;
      pulls[i] = 0;
    end
    eps_q = EPSILON_RESET;
    arms_q = ARM_COUNT_RESET;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: all ties at zero, explore edges, reward extremes
    word_q.push_back(make_word(ACT_CHOOSE, 0, 0, 16'hFFFF, 0, 16'hFFFF));
    word_q.push_back(make_word(ACT_CHOOSE, 0, 0, 16'd6554, 16'hFFFF, 3));
    word_q.push_back(make_word(ACT_CHOOSE, 0, 0, 16'd6555, 0, 0));
    word_q.push_back(make_word(ACT_UPDATE, 4'd15, 32'h7FFFFFFF, 0, 0, 0));
    word_q.push_back(make_word(ACT_UPDATE, 4'd0, 32'h80000000, 0, 0, 0));
    word_q.push_back(make_word(ACT_UPDATE, 4'd3, 32'h00030000, 0, 0, 0));
    word_q.push_back(make_word(ACT_UPDATE, 4'd3, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    word_q.push_back(make_word(ACT_CHOOSE, 0, 0, 16'hFFFF, 0, 0));
    word_q.push_back(make_word(ACT_UPDATE, 4'd5, 32'h00030000, 0, 0, 0));
    word_q.push_back(make_word(ACT_CHOOSE, 0, 0, 16'hFFFF, 0, 16'hFFFF));
    drain();

    write_reg(CFG_EPSILON, 17'd0);
    write_reg(CFG_ARM_COUNT, 17'd0);
    word_q.push_back(make_word(ACT_CHOOSE, 0, 0, 0, 16'hFFFF, 7));
    word_q.push_back(make_word(ACT_CHOOSE, 0, 0, 1, 16'hFFFF, 7));
    drain();
    write_reg(CFG_EPSILON, 17'd65536);
    write_reg(CFG_ARM_COUNT, 17'd31);
    word_q.push_back(make_word(ACT_CHOOSE, 0, 0, 16'hFFFF, 16'hFFFF, 9));
    word_q.push_back(make_word(ACT_CHOOSE, 0, 0, 0, 16'd17, 9));
    drain();

    // random phases over several settings
    eps_set = '{17'd0, 17'd65536, 17'd6554, 17'd32768, 17'd65535, 17'd1000};
    arm_set = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd7, 5'd0};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_EPSILON, eps_set[p]);
      write_reg(CFG_ARM_COUNT, 17'(arm_set[p]));
      if (p == 5) calm = 1;
      for (int k = 0; k < 280; k++) word_q.push_back(random_word());
      drain();
    end

    if (errors == 0) begin
      $display("tb_epsilon_greedy_bandit_agent: clean");
    end else begin
      $display("tb_epsilon_greedy_bandit_agent: errors");
    end
    $finish;
  end

endmodule
